>>> hdl/ahc_pkg.sv
// Shared constants, codes and types for the adaptive Huffman coder.
`timescale 1ns / 1ps
`default_nettype none

package ahc_pkg;

    // Model size
    localparam int NUM_SYMBOLS  = 629;
    localparam int MAX_CODE_LEN = 50;

    // Field and node widths
    localparam int SYM_W     = 10;
    localparam int WT_W      = 11;
    localparam int NODE_W    = $clog2(2 * NUM_SYMBOLS);
    localparam int KID_AW    = $clog2(NUM_SYMBOLS);
    localparam int CODE_W    = MAX_CODE_LEN;
    localparam int CODE_IW   = $clog2(CODE_W);
    localparam int LEN_W     = $clog2(MAX_CODE_LEN + 1);
    localparam int KIND_W    = 2;
    localparam int S_TDATA_W = ((SYM_W + 1 + 7) / 8) * 8;
    localparam int M_PAY_W   = CODE_W + LEN_W + SYM_W;
    localparam int M_TDATA_W = ((M_PAY_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 2;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [WT_W-1:0]   weight_t;

    localparam node_t   ROOT_NODE     = node_t'(1);
    localparam node_t   FIRST_LEAF    = node_t'(NUM_SYMBOLS);
    localparam node_t   LAST_NODE     = node_t'(2 * NUM_SYMBOLS - 1);
    localparam weight_t RESCALE_RESET = weight_t'(2000);

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_ENCODE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DECODE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_INIT, ST_IDLE, ST_DISPATCH,
        ST_E_RDPAR, ST_E_RDRC, ST_E_CHK,
        ST_D_RD, ST_D_CHK,
        ST_U_RD, ST_U_INC, ST_U_SIB,
        ST_P_RD, ST_P_SUM, ST_P_UP, ST_P_SIB,
        ST_R_RD, ST_R_CHK, ST_H_RD, ST_H_WR,
        ST_L_PAR, ST_L_KIDS, ST_L_WTS, ST_L_CMP, ST_L_SW1, ST_L_SW2, ST_L_NEXT,
        ST_OUT
    } state_t;

    // Datapath operations
    typedef enum logic [4:0] {
        OP_NONE, OP_INIT, OP_ACCEPT, OP_DISPATCH,
        OP_E_RDPAR, OP_E_RDRC, OP_E_CHK,
        OP_D_RD, OP_D_CHK,
        OP_U_RD, OP_U_INC, OP_U_SIB,
        OP_P_RD, OP_P_SUM, OP_P_UP, OP_P_SIB,
        OP_R_RD, OP_R_CHK, OP_H_RD, OP_H_WR,
        OP_L_PAR, OP_L_KIDS, OP_L_WTS, OP_L_CMP, OP_L_SW1, OP_L_SW2, OP_L_NEXT,
        OP_OUT
    } op_t;

    // Datapath flags seen by the sequencer
    typedef struct packed {
        logic              in_valid;
        logic              out_busy;
        logic [KIND_W-1:0] kind;
        logic              sym_ok;
        logic              len_full;
        logic              walk_root;
        logic              dec_leaf;
        logic              upd_root;
        logic              prop_root;
        logic              rescale_hit;
        logic              idx_last;
        logic              swap_hit;
        logic              loop_end;
    } status_t;

endpackage

`default_nettype wire

>>> hdl/ahc_ctrl.sv
// Sequencer for the adaptive Huffman coder: walks encode, decode and model update steps.
`timescale 1ns / 1ps
`default_nettype none

module ahc_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire ahc_pkg::status_t status,
    output ahc_pkg::op_t          op,
    output logic                  s_ready
);

    ahc_pkg::state_t state_reg, state_next;
    logic            ret_swap_reg, ret_swap_next;
    logic            restart_reg, restart_next;
    ahc_pkg::state_t ret_state;

    // Hold state and return point
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ahc_pkg::ST_INIT;
            ret_swap_reg <= 1'b0;
            restart_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ret_swap_reg <= ret_swap_next;
            restart_reg  <= restart_next;
        end
    end

    // Resume point after a weight propagation
    assign ret_state = ret_swap_reg ? ahc_pkg::ST_L_NEXT : ahc_pkg::ST_L_PAR;

    // Advance the sequence and issue one datapath operation per cycle, none while idle or stalled on a waiting result
    always_comb begin
        state_next    = state_reg;
        ret_swap_next = ret_swap_reg;
        restart_next  = restart_reg;
        op            = ahc_pkg::OP_NONE;
        s_ready       = 1'b0;
        unique case (state_reg)
            ahc_pkg::ST_INIT: begin
                op = ahc_pkg::OP_INIT;
                if (status.idx_last) begin
                    state_next = restart_reg ? ahc_pkg::ST_OUT : ahc_pkg::ST_IDLE;
                end
            end
            ahc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (status.in_valid) begin
                    op         = ahc_pkg::OP_ACCEPT;
                    state_next = ahc_pkg::ST_DISPATCH;
                end
            end
            ahc_pkg::ST_DISPATCH: begin
                op = ahc_pkg::OP_DISPATCH;
                unique case (status.kind)
                    ahc_pkg::KIND_ENCODE: begin
                        state_next = status.sym_ok ? ahc_pkg::ST_E_RDPAR : ahc_pkg::ST_OUT;
                    end
                    ahc_pkg::KIND_DECODE: begin
                        state_next = ahc_pkg::ST_D_RD;
                    end
                    ahc_pkg::KIND_RESTART: begin
                        restart_next = 1'b1;
                        state_next   = ahc_pkg::ST_INIT;
                    end
                    default: begin
                        state_next = ahc_pkg::ST_OUT;
                    end
                endcase
            end
            ahc_pkg::ST_E_RDPAR: begin
                op         = ahc_pkg::OP_E_RDPAR;
                state_next = status.len_full ? ahc_pkg::ST_U_RD : ahc_pkg::ST_E_RDRC;
            end
            ahc_pkg::ST_E_RDRC: begin
                op         = ahc_pkg::OP_E_RDRC;
                state_next = ahc_pkg::ST_E_CHK;
            end
            ahc_pkg::ST_E_CHK: begin
                op         = ahc_pkg::OP_E_CHK;
                state_next = status.walk_root ? ahc_pkg::ST_U_RD : ahc_pkg::ST_E_RDPAR;
            end
            ahc_pkg::ST_D_RD: begin
                op         = ahc_pkg::OP_D_RD;
                state_next = ahc_pkg::ST_D_CHK;
            end
            ahc_pkg::ST_D_CHK: begin
                op         = ahc_pkg::OP_D_CHK;
                state_next = status.dec_leaf ? ahc_pkg::ST_U_RD : ahc_pkg::ST_OUT;
            end
            ahc_pkg::ST_U_RD: begin
                op         = ahc_pkg::OP_U_RD;
                state_next = ahc_pkg::ST_U_INC;
            end
            ahc_pkg::ST_U_INC: begin
                op         = ahc_pkg::OP_U_INC;
                state_next = status.upd_root ? ahc_pkg::ST_OUT : ahc_pkg::ST_U_SIB;
            end
            ahc_pkg::ST_U_SIB: begin
                op            = ahc_pkg::OP_U_SIB;
                ret_swap_next = 1'b0;
                state_next    = ahc_pkg::ST_P_RD;
            end
            ahc_pkg::ST_P_RD: begin
                op         = ahc_pkg::OP_P_RD;
                state_next = ahc_pkg::ST_P_SUM;
            end
            ahc_pkg::ST_P_SUM: begin
                op         = ahc_pkg::OP_P_SUM;
                state_next = status.prop_root ? ahc_pkg::ST_R_RD : ahc_pkg::ST_P_UP;
            end
            ahc_pkg::ST_P_UP: begin
                op         = ahc_pkg::OP_P_UP;
                state_next = ahc_pkg::ST_P_SIB;
            end
            ahc_pkg::ST_P_SIB: begin
                op         = ahc_pkg::OP_P_SIB;
                state_next = ahc_pkg::ST_P_RD;
            end
            ahc_pkg::ST_R_RD: begin
                op         = ahc_pkg::OP_R_RD;
                state_next = ahc_pkg::ST_R_CHK;
            end
            ahc_pkg::ST_R_CHK: begin
                op         = ahc_pkg::OP_R_CHK;
                state_next = status.rescale_hit ? ahc_pkg::ST_H_RD : ret_state;
            end
            ahc_pkg::ST_H_RD: begin
                op         = ahc_pkg::OP_H_RD;
                state_next = ahc_pkg::ST_H_WR;
            end
            ahc_pkg::ST_H_WR: begin
                op         = ahc_pkg::OP_H_WR;
                state_next = status.idx_last ? ret_state : ahc_pkg::ST_H_RD;
            end
            ahc_pkg::ST_L_PAR: begin
                op         = ahc_pkg::OP_L_PAR;
                state_next = ahc_pkg::ST_L_KIDS;
            end
            ahc_pkg::ST_L_KIDS: begin
                op         = ahc_pkg::OP_L_KIDS;
                state_next = ahc_pkg::ST_L_WTS;
            end
            ahc_pkg::ST_L_WTS: begin
                op         = ahc_pkg::OP_L_WTS;
                state_next = ahc_pkg::ST_L_CMP;
            end
            ahc_pkg::ST_L_CMP: begin
                op         = ahc_pkg::OP_L_CMP;
                state_next = status.swap_hit ? ahc_pkg::ST_L_SW1 : ahc_pkg::ST_L_NEXT;
            end
            ahc_pkg::ST_L_SW1: begin
                op         = ahc_pkg::OP_L_SW1;
                state_next = ahc_pkg::ST_L_SW2;
            end
            ahc_pkg::ST_L_SW2: begin
                op            = ahc_pkg::OP_L_SW2;
                ret_swap_next = 1'b1;
                state_next    = ahc_pkg::ST_P_RD;
            end
            ahc_pkg::ST_L_NEXT: begin
                op         = ahc_pkg::OP_L_NEXT;
                state_next = status.loop_end ? ahc_pkg::ST_OUT : ahc_pkg::ST_L_PAR;
            end
            ahc_pkg::ST_OUT: begin
                if (!status.out_busy) begin
                    op           = ahc_pkg::OP_OUT;
                    restart_next = 1'b0;
                    state_next   = ahc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ahc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/ahc_dpath.sv
// Tree memories, walk registers and result register of the adaptive Huffman coder.
`timescale 1ns / 1ps
`default_nettype none

module ahc_dpath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire ahc_pkg::op_t                      op,
    output ahc_pkg::status_t                       status,
    input  wire logic                              s_valid,
    input  wire logic [ahc_pkg::KIND_W-1:0]        in_kind,
    input  wire logic [ahc_pkg::SYM_W-1:0]         in_symbol,
    input  wire logic                              in_coded_bit,
    input  wire logic                              cfg_we,
    input  wire logic [ahc_pkg::WT_W-1:0]          cfg_wdata,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [ahc_pkg::CODE_W-1:0]             out_code_bits,
    output logic [ahc_pkg::LEN_W-1:0]              out_code_length,
    output logic [ahc_pkg::SYM_W-1:0]              out_decoded_symbol,
    output logic                                   out_symbol_ready,
    output logic                                   out_code_overflow
);

    localparam int NODES = 2 * ahc_pkg::NUM_SYMBOLS;

    // Tree storage
    ahc_pkg::node_t   lc_mem  [ahc_pkg::NUM_SYMBOLS];
    ahc_pkg::node_t   rc_mem  [ahc_pkg::NUM_SYMBOLS];
    ahc_pkg::node_t   par_mem [NODES];
    ahc_pkg::weight_t wt_mem  [NODES];

    ahc_pkg::node_t   rd_lc_reg, rd_rc_reg, rd_par_reg;
    ahc_pkg::weight_t rd_wta_reg, rd_wtb_reg;

    // Item and walk registers
    logic [ahc_pkg::KIND_W-1:0] kind_reg;
    logic [ahc_pkg::SYM_W-1:0]  sym_reg, dsym_reg;
    logic                       bit_reg, ready_reg, ovf_reg;
    logic                       left_ua_reg, left_a_reg;
    logic [ahc_pkg::CODE_W-1:0] code_reg;
    logic [ahc_pkg::LEN_W-1:0]  len_reg;
    ahc_pkg::node_t             w_reg, p_reg, a_reg, ua_reg, uua_reg, b_reg, c_reg;
    ahc_pkg::node_t             pa_reg, pb_reg, idx_reg, cursor_reg;
    ahc_pkg::weight_t           limit_reg;

    // Result register
    logic                       out_valid_reg, out_ready_reg, out_ovf_reg;
    logic [ahc_pkg::CODE_W-1:0] out_code_reg;
    logic [ahc_pkg::LEN_W-1:0]  out_len_reg;
    logic [ahc_pkg::SYM_W-1:0]  out_dsym_reg;

    // Port controls
    logic             lc_we, rc_we, par_we, wt_we;
    ahc_pkg::node_t   lc_wd, rc_wd, par_wd, par_wa, wt_wa, kid_wa;
    ahc_pkg::weight_t wt_wd;
    ahc_pkg::node_t   kid_ra, par_ra, wta_ra, wtb_ra;

    // Helpers
    ahc_pkg::node_t leaf_sym, dec_node, uncle, sib_a, sib_p;
    logic           len_full;

    assign leaf_sym = ahc_pkg::FIRST_LEAF + ahc_pkg::node_t'(sym_reg);
    assign dec_node = bit_reg ? rd_rc_reg : rd_lc_reg;
    assign uncle    = (rd_lc_reg == ua_reg) ? rd_rc_reg : rd_lc_reg;
    assign sib_a    = (rd_lc_reg == a_reg) ? rd_rc_reg : rd_lc_reg;
    assign sib_p    = (rd_lc_reg == pa_reg) ? rd_rc_reg : rd_lc_reg;
    assign len_full = (len_reg >= ahc_pkg::LEN_W'(ahc_pkg::MAX_CODE_LEN));

    // Select memory addresses and writes for the current operation
    always_comb begin
        lc_we  = 1'b0;
        rc_we  = 1'b0;
        par_we = 1'b0;
        wt_we  = 1'b0;
        kid_wa = '0;
        lc_wd  = '0;
        rc_wd  = '0;
        par_wa = '0;
        par_wd = '0;
        wt_wa  = '0;
        wt_wd  = '0;
        kid_ra = '0;
        par_ra = '0;
        wta_ra = '0;
        wtb_ra = '0;
        case (op)
            ahc_pkg::OP_INIT: begin
                lc_we  = (idx_reg < ahc_pkg::FIRST_LEAF);
                rc_we  = (idx_reg < ahc_pkg::FIRST_LEAF);
                kid_wa = idx_reg;
                lc_wd  = {idx_reg[ahc_pkg::NODE_W-2:0], 1'b0};
                rc_wd  = {idx_reg[ahc_pkg::NODE_W-2:0], 1'b1};
                par_we = 1'b1;
                par_wa = idx_reg;
                par_wd = idx_reg >> 1;
                wt_we  = 1'b1;
                wt_wa  = idx_reg;
                wt_wd  = ahc_pkg::weight_t'(1);
            end
            ahc_pkg::OP_E_RDPAR: par_ra = w_reg;
            ahc_pkg::OP_E_RDRC:  kid_ra = rd_par_reg;
            ahc_pkg::OP_D_RD:    kid_ra = cursor_reg;
            ahc_pkg::OP_U_RD: begin
                wta_ra = leaf_sym;
                par_ra = leaf_sym;
            end
            ahc_pkg::OP_U_INC: begin
                wt_we  = 1'b1;
                wt_wa  = a_reg;
                wt_wd  = rd_wta_reg + ahc_pkg::weight_t'(1);
                kid_ra = rd_par_reg;
            end
            ahc_pkg::OP_P_RD: begin
                wta_ra = pa_reg;
                wtb_ra = pb_reg;
                par_ra = pa_reg;
            end
            ahc_pkg::OP_P_SUM: begin
                wt_we  = 1'b1;
                wt_wa  = rd_par_reg;
                wt_wd  = rd_wta_reg + rd_wtb_reg;
                par_ra = rd_par_reg;
            end
            ahc_pkg::OP_P_UP:   kid_ra = rd_par_reg;
            ahc_pkg::OP_R_RD:   wta_ra = ahc_pkg::ROOT_NODE;
            ahc_pkg::OP_H_RD:   wta_ra = idx_reg;
            ahc_pkg::OP_H_WR: begin
                wt_we = 1'b1;
                wt_wa = idx_reg;
                wt_wd = rd_wta_reg >> 1;
            end
            ahc_pkg::OP_L_PAR:  par_ra = ua_reg;
            ahc_pkg::OP_L_KIDS: kid_ra = rd_par_reg;
            ahc_pkg::OP_L_WTS: begin
                wta_ra = a_reg;
                wtb_ra = uncle;
                kid_ra = ua_reg;
            end
            ahc_pkg::OP_L_SW1: begin
                // hang the climbing node under the grandparent
                kid_wa = uua_reg;
                lc_wd  = a_reg;
                rc_wd  = a_reg;
                rc_we  = left_ua_reg;
                lc_we  = !left_ua_reg;
                par_we = 1'b1;
                par_wa = b_reg;
                par_wd = ua_reg;
            end
            ahc_pkg::OP_L_SW2: begin
                // put the uncle in the freed slot
                kid_wa = ua_reg;
                lc_wd  = b_reg;
                rc_wd  = b_reg;
                lc_we  = left_a_reg;
                rc_we  = !left_a_reg;
                par_we = 1'b1;
                par_wa = a_reg;
                par_wd = uua_reg;
            end
            default: ;
        endcase
    end

    // Child tables
    always_ff @(posedge aclk) begin
        if (lc_we) begin
            lc_mem[kid_wa[ahc_pkg::KID_AW-1:0]] <= lc_wd;
        end
        if (rc_we) begin
            rc_mem[kid_wa[ahc_pkg::KID_AW-1:0]] <= rc_wd;
        end
        rd_lc_reg <= lc_mem[kid_ra[ahc_pkg::KID_AW-1:0]];
        rd_rc_reg <= rc_mem[kid_ra[ahc_pkg::KID_AW-1:0]];
    end

    // Parent table
    always_ff @(posedge aclk) begin
        if (par_we) begin
            par_mem[par_wa] <= par_wd;
        end
        rd_par_reg <= par_mem[par_ra];
    end

    // Weight table, two read ports
    always_ff @(posedge aclk) begin
        if (wt_we) begin
            wt_mem[wt_wa] <= wt_wd;
        end
        rd_wta_reg <= wt_mem[wta_ra];
        rd_wtb_reg <= wt_mem[wtb_ra];
    end

    // Step the walk registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            cursor_reg    <= ahc_pkg::ROOT_NODE;
            limit_reg     <= ahc_pkg::RESCALE_RESET;
            out_valid_reg <= 1'b0;
            out_code_reg  <= '0;
            out_len_reg   <= '0;
            out_dsym_reg  <= '0;
            out_ready_reg <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
            // Drop the result once taken, unless a new one loads now
            if (out_valid_reg && out_ready && (op != ahc_pkg::OP_OUT)) begin
                out_valid_reg <= 1'b0;
            end
            case (op)
                ahc_pkg::OP_INIT: idx_reg <= idx_reg + ahc_pkg::node_t'(1);
                ahc_pkg::OP_ACCEPT: begin
                    if (s_valid) begin
                        kind_reg  <= in_kind;
                        sym_reg   <= in_symbol;
                        bit_reg   <= in_coded_bit;
                        w_reg     <= ahc_pkg::FIRST_LEAF + ahc_pkg::node_t'(in_symbol);
                        len_reg   <= '0;
                        code_reg  <= '0;
                        ovf_reg   <= 1'b0;
                        dsym_reg  <= '0;
                        ready_reg <= 1'b0;
                    end
                end
                ahc_pkg::OP_DISPATCH: begin
                    idx_reg <= '0;
                    if (kind_reg == ahc_pkg::KIND_RESTART) begin
                        cursor_reg <= ahc_pkg::ROOT_NODE;
                    end
                end
                ahc_pkg::OP_E_RDPAR: begin
                    if (len_full) begin
                        ovf_reg <= 1'b1;
                    end
                end
                ahc_pkg::OP_E_RDRC: p_reg <= rd_par_reg;
                ahc_pkg::OP_E_CHK: begin
                    if (rd_rc_reg == w_reg) begin
                        code_reg[len_reg[ahc_pkg::CODE_IW-1:0]] <= 1'b1;
                    end
                    len_reg <= len_reg + ahc_pkg::LEN_W'(1);
                    w_reg   <= p_reg;
                end
                ahc_pkg::OP_D_CHK: begin
                    if (dec_node >= ahc_pkg::FIRST_LEAF) begin
                        dsym_reg   <= ahc_pkg::SYM_W'(dec_node - ahc_pkg::FIRST_LEAF);
                        sym_reg    <= ahc_pkg::SYM_W'(dec_node - ahc_pkg::FIRST_LEAF);
                        ready_reg  <= 1'b1;
                        cursor_reg <= ahc_pkg::ROOT_NODE;
                    end else begin
                        cursor_reg <= dec_node;
                    end
                end
                ahc_pkg::OP_U_RD:  a_reg  <= leaf_sym;
                ahc_pkg::OP_U_INC: ua_reg <= rd_par_reg;
                ahc_pkg::OP_U_SIB: begin
                    pa_reg <= a_reg;
                    pb_reg <= sib_a;
                end
                ahc_pkg::OP_P_SUM: pa_reg <= rd_par_reg;
                ahc_pkg::OP_P_SIB: pb_reg <= sib_p;
                ahc_pkg::OP_R_CHK: idx_reg <= ahc_pkg::ROOT_NODE;
                ahc_pkg::OP_H_WR:  idx_reg <= idx_reg + ahc_pkg::node_t'(1);
                ahc_pkg::OP_L_KIDS: uua_reg <= rd_par_reg;
                ahc_pkg::OP_L_WTS: begin
                    left_ua_reg <= (rd_lc_reg == ua_reg);
                    b_reg       <= uncle;
                end
                ahc_pkg::OP_L_CMP: begin
                    left_a_reg <= (rd_lc_reg == a_reg);
                    c_reg      <= sib_a;
                end
                ahc_pkg::OP_L_SW2: begin
                    pa_reg <= b_reg;
                    pb_reg <= c_reg;
                end
                ahc_pkg::OP_L_NEXT: begin
                    a_reg  <= ua_reg;
                    ua_reg <= uua_reg;
                end
                ahc_pkg::OP_OUT: begin
                    out_valid_reg <= 1'b1;
                    out_code_reg  <= ovf_reg ? '0 : code_reg;
                    out_len_reg   <= ovf_reg ? '0 : len_reg;
                    out_dsym_reg  <= dsym_reg;
                    out_ready_reg <= ready_reg;
                    out_ovf_reg   <= ovf_reg;
                end
                default: ;
            endcase
        end
    end

    // Flags for the sequencer
    always_comb begin
        status             = '0;
        status.in_valid    = s_valid;
        status.out_busy    = out_valid_reg && !out_ready;
        status.kind        = kind_reg;
        status.sym_ok      = (ahc_pkg::node_t'(sym_reg) < ahc_pkg::FIRST_LEAF);
        status.len_full    = len_full;
        status.walk_root   = (p_reg == ahc_pkg::ROOT_NODE);
        status.dec_leaf    = (dec_node >= ahc_pkg::FIRST_LEAF);
        status.upd_root    = (rd_par_reg == ahc_pkg::ROOT_NODE);
        status.prop_root   = (rd_par_reg == ahc_pkg::ROOT_NODE);
        status.rescale_hit = (rd_wta_reg == limit_reg);
        status.idx_last    = (idx_reg == ahc_pkg::LAST_NODE);
        status.swap_hit    = (rd_wta_reg > rd_wtb_reg);
        status.loop_end    = (uua_reg == ahc_pkg::ROOT_NODE);
    end

    assign out_valid          = out_valid_reg;
    assign out_code_bits      = out_code_reg;
    assign out_code_length    = out_len_reg;
    assign out_decoded_symbol = out_dsym_reg;
    assign out_symbol_ready   = out_ready_reg;
    assign out_code_overflow  = out_ovf_reg;

    // An overflowed encode carries no path
    a_ovf_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        out_ovf_reg |-> (out_len_reg == '0) && (out_code_reg == '0))
        else $error("overflow result carries path bits");

    // A finished decode carries no path and no overflow
    a_dec_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        out_ready_reg |-> (out_len_reg == '0) && !out_ovf_reg)
        else $error("decode result carries encode fields");

    // The decode cursor always rests on an internal node
    a_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        (cursor_reg != '0) && (cursor_reg < ahc_pkg::FIRST_LEAF))
        else $error("decode cursor left the internal nodes");

    // Loading a result always shows it next cycle
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == ahc_pkg::OP_OUT) |=> out_valid_reg)
        else $error("result not presented after load");

endmodule

`default_nettype wire

>>> hdl/adaptive_huffman_coder.sv
// Top level of the adaptive Huffman coder: stream ports, sequencer and datapath.
//
//  channel   | direction | payload
//  ----------+-----------+------------------------------------------------------
//  s_ (item) | in        | tuser: kind; tdata: symbol, coded_bit
//  m_ (item) | out       | tdata: code_bits, code_length, decoded_symbol;
//            |           | tuser: symbol_ready, code_overflow
//  cfg_      | in        | rescale_limit write, no read-back
//
// One item at a time. An encode walks the path with parent read, child read and check
// steps per level, then the update: a weight propagation of read, sum, climb and sibling
// steps per level and a swap loop of parent, kids, weights, compare and next steps per
// level, plus a propagation per swap. A rescale halves the weight of every node.
// After reset and after a restart item, a clearing pass over all nodes rebuilds
// the tree; no item is accepted meanwhile. A waiting result stalls only the final load.
`timescale 1ns / 1ps
`default_nettype none

module adaptive_huffman_coder (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [ahc_pkg::S_TDATA_W-1:0]     s_tdata,   // symbol, coded_bit, zero pad
    input  wire logic [ahc_pkg::KIND_W-1:0]        s_tuser,   // kind
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [ahc_pkg::M_TDATA_W-1:0]          m_tdata,   // code_bits, code_length,
                                                              // decoded_symbol, zero pad
    output logic [ahc_pkg::M_TUSER_W-1:0]          m_tuser,   // symbol_ready, code_overflow
    input  wire logic                              cfg_we,
    input  wire logic [ahc_pkg::WT_W-1:0]          cfg_wdata
);

    ahc_pkg::op_t               op;
    ahc_pkg::status_t           status;
    logic [ahc_pkg::CODE_W-1:0] code_bits;
    logic [ahc_pkg::LEN_W-1:0]  code_length;
    logic [ahc_pkg::SYM_W-1:0]  decoded_symbol;
    logic                       symbol_ready, code_overflow;

    // Sequencer
    ahc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .op      (op),
        .s_ready (s_tready)
    );

    // Tree memories and registers
    ahc_dpath u_dpath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .op                 (op),
        .status             (status),
        .s_valid            (s_tvalid),
        .in_kind            (s_tuser),
        .in_symbol          (s_tdata[ahc_pkg::SYM_W-1:0]),
        .in_coded_bit       (s_tdata[ahc_pkg::SYM_W]),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .out_valid          (m_tvalid),
        .out_ready          (m_tready),
        .out_code_bits      (code_bits),
        .out_code_length    (code_length),
        .out_decoded_symbol (decoded_symbol),
        .out_symbol_ready   (symbol_ready),
        .out_code_overflow  (code_overflow)
    );

    // Pack the result item
    assign m_tdata = ahc_pkg::M_TDATA_W'({decoded_symbol, code_length, code_bits});
    assign m_tuser = {code_overflow, symbol_ready};

endmodule

`default_nettype wire
